/* rtl/core/cwm_pkg.sv */
// Shared types and constants of the cross-window morphology filter.
// Used by cwm_front, cwm_queue, cwm_back and cross_window_morphology.
`timescale 1ns / 1ps
`default_nettype none

package cwm_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_IDX_W = 13;

    // Register reset values
    localparam logic [PIX_W-1:0]      RST_TARGET = 8'd35;
    localparam logic [PIX_W-1:0]      RST_BG     = 8'd46;
    localparam logic [CFG_SIZE_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [CFG_SIZE_W-1:0] RST_HEIGHT = 11'd1024;

    // Result queue between classification and output
    localparam int Q_DEPTH = 4;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_TARGET = 3'd1,
        REG_BG     = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } cfg_reg_t;

    // One queued word: the results caused by one input pixel
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] prev_pixel;
        logic [PIX_W-1:0] own_pixel;
        logic             has_prev;
        logic             has_own;
        logic             frame_end;
    } cwm_entry_t;

    // Last valid index for a programmed size: zero reads as one, large values saturate
    function automatic logic [SIZE_IDX_W-1:0] last_index(
        input logic [CFG_SIZE_W-1:0] v,
        input logic [SIZE_IDX_W-1:0] maxv
    );
        logic [SIZE_IDX_W-1:0] ext;
        ext = SIZE_IDX_W'(v);
        if (ext == '0)
            return '0;
        else if (ext > maxv)
            return maxv - SIZE_IDX_W'(1);
        else
            return ext - SIZE_IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cwm_queue.sv */
// Short result queue between the front (classification) and back (output) parts.
// Depends on cwm_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cwm_queue
    import cwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cwm_entry_t       push_entry,
    input  wire logic             pop,
    output      cwm_entry_t       head,
    output      logic             empty,
    output      logic [CNT_W-1:0] count
);

    localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    cwm_entry_t             slots_reg [Q_DEPTH];
    logic [PtrW-1:0]        wr_ptr_reg;
    logic [PtrW-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Q_DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    assign head  = slots_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < CNT_W'(Q_DEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

/* rtl/core/cwm_front.sv */
// Front part: configuration registers, raster position, three-row line memory
// and the cross-window classification of each accepted pixel. Depends on cwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwm_front
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  pixel_valid,
    output      logic                  pixel_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic [CNT_W-1:0]      q_count,
    output      logic                  q_push,
    output      cwm_entry_t            q_entry
);

    localparam int ColW   = $clog2(MAX_WIDTH);
    localparam int RowW   = $clog2(MAX_HEIGHT);
    localparam int MemD   = 3 * MAX_WIDTH;
    localparam int AddrW  = $clog2(MemD);
    localparam logic [ColW-1:0] LastColRst =
        ColW'(last_index(RST_WIDTH, SIZE_IDX_W'(MAX_WIDTH)));
    localparam logic [RowW-1:0] LastRowRst =
        RowW'(last_index(RST_HEIGHT, SIZE_IDX_W'(MAX_HEIGHT)));

    // Configuration
    logic                 mode_reg;
    logic [PIX_W-1:0]     target_reg;
    logic [PIX_W-1:0]     bg_reg;
    logic [ColW-1:0]      last_col_reg;
    logic [RowW-1:0]      last_row_reg;

    // Raster position of the next pixel
    logic [ColW-1:0]      col_reg;
    logic [RowW-1:0]      row_reg;
    logic [1:0]           slot_reg;
    logic [ColW-1:0]      col_next;
    logic [RowW-1:0]      row_next;
    logic [1:0]           slot_next;

    // Line memory
    logic [PIX_W-1:0]     line_mem [MemD];
    logic [AddrW-1:0]     wr_addr;
    logic [AddrW-1:0]     rd_a_addr;
    logic [AddrW-1:0]     rd_b_addr;
    logic [PIX_W-1:0]     rd_a_reg;
    logic [PIX_W-1:0]     rd_b_reg;

    // Classification stage
    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_pixel_reg;
    logic [ColW-1:0]      s1_col_reg;
    logic [RowW-1:0]      s1_row_reg;
    logic                 s1_first_col_reg;
    logic                 s1_interior_reg;
    logic                 s1_has_prev_reg;
    logic                 s1_last_row_reg;
    logic                 s1_frame_end_reg;
    logic [PIX_W-1:0]     win_centre_reg;
    logic [PIX_W-1:0]     win_left_reg;

    logic                 cfg_acc;
    logic                 pix_acc;
    logic [CNT_W:0]       occupancy;
    logic                 at_last_col;
    logic                 at_last_row;
    logic [1:0]           mid_slot;
    logic [1:0]           top_slot;
    logic [ColW-1:0]      right_col;
    logic [PIX_W-1:0]     centre;
    logic                 hit_up;
    logic                 hit_dn;
    logic                 hit_lf;
    logic                 hit_rt;
    logic [PIX_W-1:0]     prev_val;

    function automatic logic [AddrW-1:0] row_base(input logic [1:0] s);
        logic [AddrW-1:0] b;
        case (s)
            2'd0:    b = '0;
            2'd1:    b = AddrW'(MAX_WIDTH);
            default: b = AddrW'(2 * MAX_WIDTH);
        endcase
        return b;
    endfunction

    // Handshakes: leave room in the queue for the word already in classification,
    // and hold pixels back while a configuration word is offered
    assign occupancy   = {1'b0, q_count} + (CNT_W + 1)'(s1_valid_reg);
    assign pixel_ready = !cfg_valid && (occupancy < (CNT_W + 1)'(Q_DEPTH));
    assign cfg_ready   = 1'b1;
    assign cfg_acc     = cfg_valid && cfg_ready;
    assign pix_acc     = pixel_valid && pixel_ready;

    // Advance raster position
    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb
    begin
        col_next  = col_reg + ColW'(1);
        row_next  = row_reg;
        slot_next = slot_reg;
        if (at_last_col)
        begin
            col_next = '0;
            if (at_last_row)
            begin
                row_next  = '0;
                slot_next = 2'd0;
            end
            else
            begin
                row_next  = row_reg + RowW'(1);
                slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
            end
        end
    end

    // Memory addresses: port A fetches the right neighbour on the middle row,
    // port B the top row, or the centre itself at the start of a row
    assign mid_slot  = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign top_slot  = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
    assign right_col = at_last_col ? col_reg : col_reg + ColW'(1);
    assign wr_addr   = row_base(slot_reg) + AddrW'(col_reg);
    assign rd_a_addr = row_base(mid_slot) + AddrW'(right_col);
    assign rd_b_addr = (col_reg == '0) ? row_base(mid_slot)
                                       : row_base(top_slot) + AddrW'(col_reg);

    // Hold configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            target_reg   <= RST_TARGET;
            bg_reg       <= RST_BG;
            last_col_reg <= LastColRst;
            last_row_reg <= LastRowRst;
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= 2'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_TARGET: target_reg <= cfg_data[PIX_W-1:0];
                    REG_BG:     bg_reg     <= cfg_data[PIX_W-1:0];
                    REG_WIDTH:
                    begin
                        last_col_reg <= ColW'(last_index(cfg_data[CFG_SIZE_W-1:0],
                                                         SIZE_IDX_W'(MAX_WIDTH)));
                        col_reg      <= '0;
                        row_reg      <= '0;
                        slot_reg     <= 2'd0;
                    end
                    REG_HEIGHT:
                    begin
                        last_row_reg <= RowW'(last_index(cfg_data[CFG_SIZE_W-1:0],
                                                         SIZE_IDX_W'(MAX_HEIGHT)));
                        col_reg      <= '0;
                        row_reg      <= '0;
                        slot_reg     <= 2'd0;
                    end
                    default: ;
                endcase
            end
            else if (pix_acc)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            s1_valid_reg <= pix_acc;
        end
    end

    // Write the new pixel, fetch its neighbours
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            line_mem[wr_addr] <= pixel;
            rd_a_reg          <= line_mem[rd_a_addr];
            rd_b_reg          <= line_mem[rd_b_addr];
        end
    end

    // Capture the classified pixel
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pixel_reg     <= pixel;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
            s1_first_col_reg <= (col_reg == '0);
            s1_interior_reg  <= (row_reg > RowW'(1)) && (col_reg != '0) &&
                                (col_reg < last_col_reg);
            s1_has_prev_reg  <= (row_reg != '0);
            s1_last_row_reg  <= at_last_row;
            s1_frame_end_reg <= at_last_row && at_last_col;
        end
        // Slide the middle-row window one column
        if (s1_valid_reg)
        begin
            win_centre_reg <= rd_a_reg;
            win_left_reg   <= centre;
        end
    end

    // Evaluate the cross window
    assign centre = s1_first_col_reg ? rd_b_reg : win_centre_reg;
    assign hit_up = (rd_b_reg == target_reg);
    assign hit_dn = (s1_pixel_reg == target_reg);
    assign hit_lf = (win_left_reg == target_reg);
    assign hit_rt = (rd_a_reg == target_reg);

    always_comb
    begin
        if (s1_interior_reg)
        begin
            if (!mode_reg)
                prev_val = (hit_up || hit_dn || hit_lf || hit_rt) ? target_reg : centre;
            else
                prev_val = (hit_up && hit_dn && hit_lf && hit_rt) ? target_reg : bg_reg;
        end
        else
        begin
            prev_val = mode_reg ? bg_reg : centre;
        end
    end

    assign q_push             = s1_valid_reg && (s1_has_prev_reg || s1_last_row_reg);
    assign q_entry.row        = POS_W'(s1_row_reg);
    assign q_entry.col        = POS_W'(s1_col_reg);
    assign q_entry.prev_pixel = prev_val;
    assign q_entry.own_pixel  = mode_reg ? bg_reg : s1_pixel_reg;
    assign q_entry.has_prev   = s1_has_prev_reg;
    assign q_entry.has_own    = s1_last_row_reg;
    assign q_entry.frame_end  = s1_frame_end_reg;

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_count < CNT_W'(Q_DEPTH)))
        else $error("classified word has no queue room");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
        else $error("raster position beyond frame size");

    a_row_wrap_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg == '0) |-> (slot_reg == 2'd0))
        else $error("row slot out of step with row counter");

endmodule

`default_nettype wire

/* rtl/core/cwm_back.sv */
// Back part: drains queued words into an output register, one or two results each.
// Depends on cwm_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module cwm_back
    import cwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cwm_entry_t       head,
    input  wire logic             empty,
    output      logic             pop,
    output      logic             result_valid,
    input  wire logic             result_ready,
    output      logic [POS_W-1:0] out_row,
    output      logic [POS_W-1:0] out_col,
    output      logic [PIX_W-1:0] out_pixel,
    output      logic             run_last,
    output      logic             frame_end
);

    logic             valid_reg;
    logic             phase_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic             run_last_reg;
    logic             frame_end_reg;

    logic             load;
    logic             emit_prev;

    // Load the output register whenever it is free or being taken
    assign load      = !empty && (!valid_reg || result_ready);
    assign emit_prev = head.has_prev && !phase_reg;
    assign pop       = load && !(emit_prev && head.has_own);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (result_ready)
                valid_reg <= 1'b0;
            if (load)
                phase_reg <= emit_prev && head.has_own;
        end
    end

    // Select the result of the row above first, then the pixel's own
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg <= head.col;
            if (emit_prev)
            begin
                row_reg       <= head.row - POS_W'(1);
                pixel_reg     <= head.prev_pixel;
                run_last_reg  <= !head.has_own;
                frame_end_reg <= 1'b0;
            end
            else
            begin
                row_reg       <= head.row;
                pixel_reg     <= head.own_pixel;
                run_last_reg  <= 1'b1;
                frame_end_reg <= head.frame_end;
            end
        end
    end

    assign result_valid = valid_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign out_pixel    = pixel_reg;
    assign run_last     = run_last_reg;
    assign frame_end    = frame_end_reg;

    a_phase_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !empty)
        else $error("second result pending with empty queue");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frame_end_reg) |-> run_last_reg)
        else $error("frame end on a result that is not last of its pixel");

endmodule

`default_nettype wire

/* rtl/core/cross_window_morphology.sv */
// Top level of the cross-window dilation / erosion filter.
// Instantiates cwm_front, cwm_queue and cwm_back; depends on cwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Binary morphology on a raster pixel stream with a plus-shaped window (four
// neighbours, centre excluded). Pixels enter one per clock while the result
// queue has room; the pixel at (r,c) releases the result for (r-1,c), and
// pixels of the last row also release their own result right after it, so
// on the last row the single output register limits the pixel rate. The
// first result a pixel releases passes the classification stage, the result
// queue and the output register in turn. Three rows of line storage
// (3*MAX_WIDTH bytes, one write and two read ports) sit in the front part; no
// clearing pass runs after reset. Pixel input pauses while a configuration
// word is offered. Writing image_width or image_height restarts the frame at
// row 0, column 0; write configuration only while no results are outstanding.
module cross_window_morphology
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  pixel_valid,
    output      logic                  pixel_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      logic [POS_W-1:0]      out_row,
    output      logic [POS_W-1:0]      out_col,
    output      logic [PIX_W-1:0]      out_pixel,
    output      logic                  run_last,
    output      logic                  frame_end
);

    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic [CNT_W-1:0] q_count;
    cwm_entry_t       q_entry;
    cwm_entry_t       q_head;

    // Accept and classify pixels
    cwm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // Buffer classified words
    cwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .count      (q_count)
    );

    // Emit results
    cwm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_pixel    (out_pixel),
        .run_last     (run_last),
        .frame_end    (frame_end)
    );

endmodule

`default_nettype wire

/* tb/sv/cwm_checker.sv */
// Cross-window morphology checker: tracks frame position and line storage,
// rebuilds every filtered output word and compares it with the block's output.
// Depends on cwm_pkg for field widths and register indexes.
`timescale 1ns / 1ps

module cwm_checker
    import cwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  pixel_valid,
    input  wire logic                  pixel_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire logic [POS_W-1:0]      out_row,
    input  wire logic [POS_W-1:0]      out_col,
    input  wire logic [PIX_W-1:0]      out_pixel,
    input  wire logic                  run_last,
    input  wire logic                  frame_end,
    output int                         mismatch_count,
    output int                         words_due
);

    localparam int LINE_LEN  = DEF_MAX_WIDTH;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last_of_pixel;
        logic             last_of_frame;
    } filtered_word_t;

    // Register copies
    logic                  erode_mode;
    logic [PIX_W-1:0]      fg_color;
    logic [PIX_W-1:0]      bg_color;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;

    // Three rows of line storage and the position of the next pixel
    logic [PIX_W-1:0] line_mem [0:3*LINE_LEN-1];
    int unsigned      row_pos;
    int unsigned      col_pos;

    filtered_word_t filtered_q [$];

    // Zero reads as one, anything above the maximum saturates
    function automatic int unsigned clamp_dim(input logic [CFG_SIZE_W-1:0] v,
                                              input int unsigned maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    task automatic take_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:   erode_mode = data[0];
            REG_TARGET: fg_color = data[PIX_W-1:0];
            REG_BG:     bg_color = data[PIX_W-1:0];
            REG_WIDTH:
            begin
                width_reg = data;
                row_pos = 0;
                col_pos = 0;
            end
            REG_HEIGHT:
            begin
                height_reg = data;
                row_pos = 0;
                col_pos = 0;
            end
            default: ;
        endcase
    endtask

    // Store the pixel, build the words it releases, advance the position
    task automatic apply_cross_window(input logic [PIX_W-1:0] p);
        int unsigned    w;
        int unsigned    h;
        int unsigned    r;
        int unsigned    c;
        int unsigned    mid;
        int unsigned    top;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] val;
        bit             up;
        bit             dn;
        bit             lf;
        bit             rt;
        filtered_word_t words [2];
        int             n;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        n = 0;
        line_mem[(r % 3) * LINE_LEN + c] = p;

        // Release the pixel one row up
        if (r >= 1)
        begin
            mid = (r + 2) % 3;
            top = (r + 1) % 3;
            centre = line_mem[mid * LINE_LEN + c];
            if (r >= 2 && r + 1 <= h && c >= 1 && c + 2 <= w)
            begin
                up = (line_mem[top * LINE_LEN + c] == fg_color);
                dn = (p == fg_color);
                lf = (line_mem[mid * LINE_LEN + c - 1] == fg_color);
                rt = (line_mem[mid * LINE_LEN + c + 1] == fg_color);
                if (!erode_mode)
                    val = (up || dn || lf || rt) ? fg_color : centre;
                else
                    val = (up && dn && lf && rt) ? fg_color : bg_color;
            end
            else
            begin
                val = erode_mode ? bg_color : centre;
            end
            words[n] = '{POS_W'(r - 1), POS_W'(c), val, 1'b0, 1'b0};
            n++;
        end

        // Last row also releases its own pixel
        if (r + 1 == h)
        begin
            words[n] = '{POS_W'(r), POS_W'(c), erode_mode ? bg_color : p, 1'b0, 1'b0};
            n++;
        end

        if (n > 0)
        begin
            words[n-1].last_of_pixel = 1'b1;
            if (r + 1 == h && c + 1 == w)
                words[n-1].last_of_frame = 1'b1;
            for (int k = 0; k < n; k++)
                filtered_q.insert(filtered_q.size(), words[k]);
        end

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_word();
        filtered_word_t want;
        if (filtered_q.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: output word expected none, actual row %0d col %0d pixel %0d",
                     $time, out_row, out_col, out_pixel);
        end
        else
        begin
            want = filtered_q.pop_front();
            check_field("out_row", 16'(want.row), 16'(out_row));
            check_field("out_col", 16'(want.col), 16'(out_col));
            check_field("out_pixel", 16'(want.value), 16'(out_pixel));
            check_field("run_last", 16'(want.last_of_pixel), 16'(run_last));
            check_field("frame_end", 16'(want.last_of_frame), 16'(frame_end));
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erode_mode     = 1'b0;
            fg_color       = RST_TARGET;
            bg_color       = RST_BG;
            width_reg      = RST_WIDTH;
            height_reg     = RST_HEIGHT;
            row_pos        = 0;
            col_pos        = 0;
            mismatch_count = 0;
            filtered_q.delete();
            words_due      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                take_register(cfg_index, cfg_data);
            if (pixel_valid && pixel_ready)
                apply_cross_window(pixel);
            if (result_valid && result_ready)
                compare_word();
            words_due = filtered_q.size();
        end
    end

endmodule

/* tb/sv/tb_cross_window_morphology.sv */
// Top of the cross-window morphology testbench: clock, reset, register writes,
// pixel stream and output back-pressure; gives the verdict.
// Depends on cwm_pkg, cross_window_morphology and cwm_checker.
`timescale 1ns / 1ps

module tb_cross_window_morphology;
    import cwm_pkg::*;

    localparam int          RANDOM_ITEMS = 250;
    localparam int          EDGE_ITEMS   = 180;
    localparam int          PHASE_CAP    = 200;
    localparam int          MAX_GAP      = 18;
    localparam int          SETTLE_CYC   = 8;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam longint      RUN_LIMIT_NS = 20_000_000;
    localparam logic [PIX_W-1:0] STAR    = 8'h23;
    localparam logic [PIX_W-1:0] DOT     = 8'h2E;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic [PIX_W-1:0]      pixel;
    logic                  result_valid;
    logic                  result_ready;
    logic [POS_W-1:0]      out_row;
    logic [POS_W-1:0]      out_col;
    logic [PIX_W-1:0]      out_pixel;
    logic                  run_last;
    logic                  frame_end;

    int                    mismatch_count;
    int                    words_due;
    logic [PIX_W-1:0]      target_now;
    logic [PIX_W-1:0]      bg_now;
    bit                    sender_steady;

    cross_window_morphology dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_pixel    (out_pixel),
        .run_last     (run_last),
        .frame_end    (frame_end)
    );

    cwm_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel          (pixel),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_pixel      (out_pixel),
        .run_last       (run_last),
        .frame_end      (frame_end),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the whole run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Send one pixel word; called and returns at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; called and returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, wait for every output word, then let the pipeline empty
    task automatic settle();
        pixel_valid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Mostly small frames, with degenerate sizes now and then
    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 6)
            return 0;
        if (k < 14)
            return 1;
        if (k < 30)
            return $urandom_range(2, 3);
        if (k < 85)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Foreground-rich content so that both window outcomes show up
    function automatic logic [PIX_W-1:0] pick_pixel(input int density);
        int k;
        k = $urandom_range(0, 9);
        if (k < density)
            return target_now;
        if (k == density)
            return bg_now;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Output side: random stalls per word, with calm stretches
    initial
    begin
        int stall;
        int taken;
        bit quiet;
        result_ready = 1'b0;
        quiet = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            @(negedge clk);
            taken++;
            if (taken % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        logic [PIX_W-1:0]      pattern [16];
        logic [CFG_DATA_W-1:0] data;
        int                    w;
        int                    h;
        int                    frame;
        int                    n;
        int                    dens;
        int                    sent;
        int                    drained;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pixel_valid   = 1'b0;
        pixel         = '0;
        sender_steady = 1'b0;
        target_now    = RST_TARGET;
        bg_now        = RST_BG;
        pattern = '{STAR, 8'h00, STAR, 8'hFF,
                    8'h41, STAR, 8'h42, 8'h43,
                    8'h44, 8'h45, 8'h46, STAR,
                    STAR, DOT, 8'hFF, 8'h00};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sizes: the first row of a full-size frame releases nothing
        repeat (3) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle();

        // Dilation on a 4x4 frame; the width write restarts the frame
        write_reg(REG_MODE, CFG_DATA_W'(0));
        write_reg(REG_TARGET, CFG_DATA_W'(STAR));
        write_reg(REG_BG, CFG_DATA_W'(DOT));
        write_reg(REG_WIDTH, CFG_DATA_W'(4));
        write_reg(REG_HEIGHT, CFG_DATA_W'(4));
        target_now = STAR;
        bg_now = DOT;
        foreach (pattern[i])
            send_pixel(pattern[i]);
        settle();

        // Unused indexes must leave everything alone
        for (int idx = int'(REG_HEIGHT) + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom_range(0, 2047)));

        // Erosion on a 3x3 frame whose centre window succeeds
        write_reg(REG_MODE, CFG_DATA_W'(1));
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_HEIGHT, CFG_DATA_W'(3));
        repeat (9) send_pixel(STAR);
        w = 3;
        h = 3;

        // Random phases: random settings, one or two frames of pixels, sometimes an odd tail, at most PHASE_CAP
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 2047)));
            if ($urandom_range(0, 2) == 0)
            begin
                data = CFG_DATA_W'($urandom_range(0, 2047));
                write_reg(REG_TARGET, data);
                target_now = data[PIX_W-1:0];
            end
            if ($urandom_range(0, 2) == 0)
            begin
                data = CFG_DATA_W'($urandom_range(0, 2047));
                write_reg(REG_BG, data);
                bg_now = data[PIX_W-1:0];
            end
            if ($urandom_range(0, 9) < 6)
            begin
                w = pick_size();
                write_reg(REG_WIDTH, CFG_DATA_W'(w));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                h = pick_size();
                write_reg(REG_HEIGHT, CFG_DATA_W'(h));
            end
            frame = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            n = frame * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(0, frame - 1);
            if (n > PHASE_CAP)
                n = PHASE_CAP;
            dens = $urandom_range(2, 9);
            repeat (n) send_pixel(pick_pixel(dens));
            sent += n;
        end

        // Widest row, saturated from the all-ones value, one row per frame:
        // the start of that row
        settle();
        sender_steady = ($urandom_range(0, 1) == 1);
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, CFG_DATA_W'(1));
        repeat (EDGE_ITEMS) send_pixel(pick_pixel(5));

        // Tallest frame, one column wide: its first rows
        settle();
        sender_steady = ($urandom_range(0, 1) == 1);
        write_reg(REG_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_HEIGHT, CFG_DATA_W'(DEF_MAX_HEIGHT));
        repeat (EDGE_ITEMS) send_pixel(pick_pixel(5));

        // Drain, then give the verdict
        pixel_valid <= 1'b0;
        drained = 0;
        while (words_due != 0 && drained < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drained++;
        end
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && words_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/cwm_pkg.sv
rtl/core/cwm_queue.sv
rtl/core/cwm_front.sv
rtl/core/cwm_back.sv
rtl/core/cross_window_morphology.sv
tb/sv/cwm_checker.sv
tb/sv/tb_cross_window_morphology.sv
